/* rtl/c3mp_pkg.sv */
// Shared types, constants and a helper function of the 3x3 convolution and 2x2 max-pool block.
`default_nettype none
package c3mp_pkg;

  localparam int MAX_WIDTH    = 512;
  localparam int MAX_HEIGHT   = 4096;
  localparam int LINES_KEPT   = 3;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int WIDTH_REG_W  = 10;
  localparam int HEIGHT_REG_W = 13;
  localparam int COEF_W       = 24;
  localparam int SHIFT_W      = 4;
  localparam int PIX_W        = 8;
  localparam int OCOL_W       = 8;
  localparam int OROW_W       = 11;
  localparam int SUM_W        = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int TAPS         = 9;
  localparam int POOL_N       = 4;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_ROW0    = 3'd0,
    REG_COEF_ROW1    = 3'd1,
    REG_COEF_ROW2    = 3'd2,
    REG_RIGHT_SHIFT  = 3'd3,
    REG_FRAME_WIDTH  = 3'd4,
    REG_FRAME_HEIGHT = 3'd5
  } c3mp_reg_t;

  typedef struct packed {
    logic [COEF_W-1:0]  coef_row0;
    logic [COEF_W-1:0]  coef_row1;
    logic [COEF_W-1:0]  coef_row2;
    logic [SHIFT_W-1:0] right_shift;
  } c3mp_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [COL_W-1:0]  col;
    logic [1:0]        bank;
    logic              emit;
    logic [OCOL_W-1:0] out_col;
    logic [OROW_W-1:0] out_row;
    logic              frame_last;
  } c3mp_item_t;

  typedef struct packed {
    logic              emit;
    logic [OCOL_W-1:0] out_col;
    logic [OROW_W-1:0] out_row;
    logic              frame_last;
  } c3mp_meta_t;

  function automatic logic [1:0] bank_add(input logic [1:0] b, input logic [1:0] n);
    logic [2:0] s;
    s = {1'b0, b} + {1'b0, n};
    bank_add = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/conv3x3_maxpool2x2_core.sv */
// Top level of the streaming 3x3 convolution and 2x2 max-pool block.
//
// Pixels enter in raster order on in_valid/in_stall/pixel; a transaction
// takes place at a rising edge with in_valid high and in_stall low. Pooled
// results leave on out_valid/out_stall with pooled_value, out_col, out_row
// and frame_last, which marks the last result of a frame.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high and writes to unused indexes are ignored.
// Configuration should change only while the block is idle.
// One pixel is accepted every cycle while in_stall is low. A result passes
// from the transaction of the pixel that completes its 2x2 group through
// the queue, the line-store read, window, products, sums and clamp/max.
// A four-entry queue parts the counters from the datapath; when the receiver
// stalls, the datapath holds and the queue fills, after which in_stall rises.
// Synchronous reset clears counters, queue and pipeline valids and loads the
// register defaults; line stores are not cleared.
`default_nettype none
module conv3x3_maxpool2x2_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [c3mp_pkg::PIX_W-1:0]        pixel,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [c3mp_pkg::PIX_W-1:0]             pooled_value,
  output logic [c3mp_pkg::OCOL_W-1:0]            out_col,
  output logic [c3mp_pkg::OROW_W-1:0]            out_row,
  output logic                                   frame_last,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [c3mp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [c3mp_pkg::COEF_W-1:0]       cfg_data
);
  import c3mp_pkg::*;

  c3mp_cfg_t               cfg;
  logic [WIDTH_REG_W-1:0]  frame_width;
  logic [HEIGHT_REG_W-1:0] frame_height;
  logic                    push, pop, full, q_valid;
  c3mp_item_t              f_item, q_item;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign push      = in_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_row0   <= '0;
      cfg.coef_row1   <= '0;
      cfg.coef_row2   <= '0;
      cfg.right_shift <= SHIFT_W'(5);
      frame_width     <= WIDTH_REG_W'(512);
      frame_height    <= HEIGHT_REG_W'(512);
    end else if (cfg_valid) begin
      case (c3mp_reg_t'(cfg_index))
        REG_COEF_ROW0:    cfg.coef_row0   <= cfg_data;
        REG_COEF_ROW1:    cfg.coef_row1   <= cfg_data;
        REG_COEF_ROW2:    cfg.coef_row2   <= cfg_data;
        REG_RIGHT_SHIFT:  cfg.right_shift <= cfg_data[SHIFT_W-1:0];
        REG_FRAME_WIDTH:  frame_width     <= cfg_data[WIDTH_REG_W-1:0];
        REG_FRAME_HEIGHT: frame_height    <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  c3mp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .pixel        (pixel),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .item         (f_item)
  );

  c3mp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (f_item),
    .full      (full),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (q_item)
  );

  c3mp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pooled_value (pooled_value),
    .out_col      (out_col),
    .out_row      (out_row),
    .frame_last   (frame_last)
  );
endmodule
`default_nettype wire

/* rtl/c3mp_ram.sv */
// Generic single-write, single-read RAM with registered read-first data.
`default_nettype none
module c3mp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end
endmodule
`default_nettype wire

/* rtl/c3mp_front.sv */
// Front end: raster counters and classification of each pixel.
`default_nettype none
module c3mp_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  input  wire logic [c3mp_pkg::PIX_W-1:0]          pixel,
  input  wire logic [c3mp_pkg::WIDTH_REG_W-1:0]    frame_width,
  input  wire logic [c3mp_pkg::HEIGHT_REG_W-1:0]   frame_height,
  output c3mp_pkg::c3mp_item_t                     item
);
  import c3mp_pkg::*;

  logic [COL_W-1:0]        col_count, col_count_next;
  logic [ROW_W-1:0]        row_count, row_count_next;
  logic [1:0]              bank, bank_next;
  logic [WIDTH_REG_W-1:0]  w;
  logic [HEIGHT_REG_W-1:0] h;
  logic [COL_W-1:0]        half_w;
  logic [ROW_W-1:0]        half_h;
  logic [COL_W-1:0]        col_off;
  logic [ROW_W-1:0]        row_off;
  logic [OCOL_W-1:0]       i_idx;
  logic [OROW_W-1:0]       j_idx;
  logic                    at_pos;
  logic                    col_end, row_end;

  always_comb begin
    w = (frame_width > WIDTH_REG_W'(MAX_WIDTH)) ? WIDTH_REG_W'(MAX_WIDTH) : frame_width;
    h = (frame_height > HEIGHT_REG_W'(MAX_HEIGHT)) ? HEIGHT_REG_W'(MAX_HEIGHT) : frame_height;
    half_w  = w[WIDTH_REG_W-1:1];
    half_h  = h[HEIGHT_REG_W-1:1];
    col_off = col_count - COL_W'(3);
    row_off = row_count - ROW_W'(3);
    i_idx   = col_off[COL_W-1:1];
    j_idx   = row_off[ROW_W-1:1];
    at_pos  = col_count[0] && row_count[0] && (col_count >= COL_W'(3))
              && (row_count >= ROW_W'(3));
    col_end = ({1'b0, col_count} + WIDTH_REG_W'(1)) >= w;
    row_end = ({1'b0, row_count} + HEIGHT_REG_W'(1)) >= h;

    item.pixel      = pixel;
    item.col        = col_count;
    item.bank       = bank;
    item.out_col    = i_idx;
    item.out_row    = j_idx;
    item.emit       = at_pos && (({1'b0, i_idx} + COL_W'(1)) < half_w)
                      && (({1'b0, j_idx} + ROW_W'(1)) < half_h);
    item.frame_last = (({1'b0, i_idx} + COL_W'(2)) == half_w)
                      && (({1'b0, j_idx} + ROW_W'(2)) == half_h);

    col_count_next = col_count;
    row_count_next = row_count;
    bank_next      = bank;
    if (col_end) begin
      col_count_next = '0;
      if (row_end) begin
        row_count_next = '0;
        bank_next      = '0;
      end else begin
        row_count_next = row_count + ROW_W'(1);
        bank_next      = bank_add(bank, 2'd1);
      end
    end else begin
      col_count_next = col_count + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      bank      <= '0;
    end else if (push) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
      bank      <= bank_next;
    end
  end
endmodule
`default_nettype wire

/* rtl/c3mp_queue.sv */
// Short queue of classified pixels between the front and back ends.
`default_nettype none
module c3mp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  c3mp_pkg::c3mp_item_t      push_item,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      not_empty,
  output c3mp_pkg::c3mp_item_t      head
);
  import c3mp_pkg::*;

  c3mp_item_t           entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [Q_PTR_W:0]     count;

  assign full      = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (Q_PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (Q_PTR_W+1)'(1);
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/c3mp_back.sv */
// Back end: line stores, 4x4 window, convolution, clamp, max-pool and output register.
`default_nettype none
module c3mp_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  c3mp_pkg::c3mp_cfg_t                cfg,
  input  wire logic                          q_valid,
  input  c3mp_pkg::c3mp_item_t               q_item,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [c3mp_pkg::PIX_W-1:0]         pooled_value,
  output logic [c3mp_pkg::OCOL_W-1:0]        out_col,
  output logic [c3mp_pkg::OROW_W-1:0]        out_row,
  output logic                               frame_last
);
  import c3mp_pkg::*;

  logic                      adv;
  logic [PIX_W-1:0]          rd_data [LINES_KEPT];
  logic                      s1_valid, s2_valid, s3_valid, s4_valid;
  logic [PIX_W-1:0]          s1_pixel;
  logic [1:0]                s1_bank;
  c3mp_meta_t                s1_meta, s2_meta, s3_meta, s4_meta;
  logic [PIX_W-1:0]          win [4][4];
  logic signed [PIX_W-1:0]   coef [3][3];
  logic [SUM_W-1:0]          prod [POOL_N][TAPS];
  logic [SUM_W-1:0]          sum [POOL_N];
  logic [SUM_W-1:0]          sum_next [POOL_N];
  logic [PIX_W-1:0]          pool_next;
  logic [SUM_W-1:0]          shifted;
  logic [PIX_W-1:0]          clamped;

  assign adv = !out_valid || !out_stall;
  assign pop = q_valid && adv;

  for (genvar k = 0; k < LINES_KEPT; k++) begin : g_line
    c3mp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line (
      .clk   (clk),
      .we    (pop && (q_item.bank == 2'(k))),
      .waddr (q_item.col),
      .wdata (q_item.pixel),
      .re    (pop),
      .raddr (q_item.col),
      .rdata (rd_data[k])
    );
  end

  for (genvar c = 0; c < 3; c++) begin : g_coef
    assign coef[0][c] = cfg.coef_row0[8*c +: 8];
    assign coef[1][c] = cfg.coef_row1[8*c +: 8];
    assign coef[2][c] = cfg.coef_row2[8*c +: 8];
  end

  always_comb begin
    for (int k = 0; k < POOL_N; k++) begin
      sum_next[k] = '0;
      for (int t = 0; t < TAPS; t++) begin
        sum_next[k] = sum_next[k] + prod[k][t];
      end
    end
  end

  always_comb begin
    pool_next = '0;
    shifted   = '0;
    clamped   = '0;
    for (int k = 0; k < POOL_N; k++) begin
      shifted = sum[k] >> cfg.right_shift;
      if (sum[k][SUM_W-1]) begin
        clamped = '0;
      end else if (shifted > SUM_W'(PIX_MAX)) begin
        clamped = PIX_MAX;
      end else begin
        clamped = shifted[PIX_W-1:0];
      end
      if (clamped > pool_next) begin
        pool_next = clamped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pixel <= q_item.pixel;
      s1_bank  <= q_item.bank;
      s1_meta  <= '{emit: q_item.emit, out_col: q_item.out_col,
                    out_row: q_item.out_row, frame_last: q_item.frame_last};
      if (s1_valid) begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 3; c++) begin
            win[r][c] <= win[r][c+1];
          end
        end
        win[0][3] <= rd_data[s1_bank];
        win[1][3] <= rd_data[bank_add(s1_bank, 2'd1)];
        win[2][3] <= rd_data[bank_add(s1_bank, 2'd2)];
        win[3][3] <= s1_pixel;
      end
      s2_meta <= s1_meta;
      for (int dr = 0; dr < 2; dr++) begin
        for (int dc = 0; dc < 2; dc++) begin
          for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
              prod[2*dr+dc][3*r+c] <= SUM_W'(coef[r][c]
                                      * $signed({1'b0, win[dr+r][dc+c]}));
            end
          end
        end
      end
      s3_meta <= s2_meta;
      sum     <= sum_next;
      s4_meta <= s3_meta;
      pooled_value <= pool_next;
      out_col      <= s4_meta.out_col;
      out_row      <= s4_meta.out_row;
      frame_last   <= s4_meta.frame_last;
    end
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= pop;
      s2_valid  <= s1_valid && s1_meta.emit;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end
endmodule
`default_nettype wire

/* rtl/c3mp_checker.sv */
// Port-level assertions for the convolution and max-pool block, with its bind.
`default_nettype none
module c3mp_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [c3mp_pkg::PIX_W-1:0]     pooled_value,
  input wire logic [c3mp_pkg::OCOL_W-1:0]    out_col,
  input wire logic [c3mp_pkg::OROW_W-1:0]    out_row,
  input wire logic                           cfg_ready
);
  import c3mp_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pooled_value))
    else $error("stalled result changed");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_col != {OCOL_W{1'b1}})
    else $error("output column beyond the widest frame");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_row != {OROW_W{1'b1}})
    else $error("output row beyond the tallest frame");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");
endmodule

bind conv3x3_maxpool2x2_core c3mp_checker u_c3mp_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .pooled_value (pooled_value),
  .out_col      (out_col),
  .out_row      (out_row),
  .cfg_ready    (cfg_ready)
);
`default_nettype wire
